### hw/rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the crc frame builder
// start byte, crc16-ccitt parameters, frame state and result group types
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [CNT_W-1:0] res_cnt_t;

  // state of the open frame
  typedef struct packed {
    logic        in_frame;
    logic [7:0]  bytes_sent;
    logic [7:0]  frame_length;
    logic [15:0] running_crc;
  } frame_state_t;

  // bytes produced by one request, slot 0 goes out first
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    res_cnt_t                    count;
    logic                        closes;
    logic                        length_error;
  } result_group_t;

  localparam frame_state_t FRAME_IDLE = '{
    in_frame:     1'b0,
    bytes_sent:   8'h00,
    frame_length: 8'h00,
    running_crc:  CRC_INIT
  };

  // one byte of crc16-ccitt, msb first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfb_encoder.sv
// ----------------------------------------------------------------------------
// cfb_encoder: framing logic for one request
// builds the group of framed bytes and the next frame state
// ----------------------------------------------------------------------------
module cfb_encoder (
  input  cfb_pkg::frame_state_t  state_i,
  input  logic [7:0]             msg_id_i,
  input  logic [7:0]             frame_len_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  output cfb_pkg::frame_state_t  state_o,
  output cfb_pkg::result_group_t group_o
);
  import cfb_pkg::*;

  frame_state_t st;
  res_cnt_t     n;

  always_comb begin
    st      = state_i;
    n       = '0;
    group_o = '0;

    // frame opening: header bytes
    if (!st.in_frame) begin
      st.in_frame     = 1'b1;
      st.bytes_sent   = 8'h00;
      st.frame_length = frame_len_i;
      st.running_crc  = crc_add(crc_add(crc_add(CRC_INIT, SYNC_BYTE), msg_id_i),
                                frame_len_i);
      group_o.bytes[0] = SYNC_BYTE;
      group_o.bytes[1] = msg_id_i;
      group_o.bytes[2] = frame_len_i;
      n = res_cnt_t'(3);
    end

    // payload byte, dropped once the stated length is reached
    if (st.bytes_sent < st.frame_length) begin
      group_o.bytes[n] = data_i;
      st.running_crc   = crc_add(st.running_crc, data_i);
      st.bytes_sent    = st.bytes_sent + 8'd1;
      n = n + res_cnt_t'(1);
    end

    // frame close: crc low then high
    if (last_i) begin
      group_o.closes       = 1'b1;
      group_o.length_error = (st.bytes_sent < st.frame_length);
      group_o.bytes[n]     = st.running_crc[7:0];
      group_o.bytes[n + res_cnt_t'(1)] = st.running_crc[15:8];
      n  = n + res_cnt_t'(2);
      st = FRAME_IDLE;
    end

    group_o.count = n;
    state_o       = st;
  end

endmodule

### hw/rtl/crc_frame_builder.sv
// ----------------------------------------------------------------------------
// crc_frame_builder: framed packet encoder with crc16-ccitt trailer
// wraps payload bytes in start byte, id, length and crc for a serial link
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): one payload byte per request; the
//   first request of a frame also carries msg_id_i and frame_len_i, and
//   last_i marks the final request of the frame
//   output channel (out_valid_o / out_ready_i): one framed byte per request,
//   in order start 0xAA, id, length, payload, crc low, crc high
//   end_of_frame_o marks the crc high byte; length_error_o is set there when
//   the frame was closed before the stated length arrived
// timing and throughput
//   the bytes of a request appear in the cycle after it is accepted
//   one request yields 0 to 6 bytes and the output port drains one byte per
//   cycle while the receiver is ready, so a request is taken every cycle while
//   each yields at most one byte; a request with more bytes holds the input
//   until its final byte leaves (frame opening: 3 or 4 bytes, frame close: 2 more)
// reset and stall
//   reset closes any open frame and empties the result group
//   while the receiver stalls the current byte holds; the next request is
//   taken in the same cycle as the final byte of the current group leaves
// ----------------------------------------------------------------------------
module crc_frame_builder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] msg_id_i,
  input  logic [7:0] frame_len_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_frame_o,
  output logic       length_error_o
);
  import cfb_pkg::*;

  // frame state and the result group register
  frame_state_t                state_q, state_d;
  result_group_t               group_d;
  logic [MAX_RESULTS-1:0][7:0] bytes_q;
  res_cnt_t                    cnt_q;
  res_cnt_t                    ptr_q;
  logic                        eof_q;
  logic                        err_q;

  logic in_accept;
  logic out_take;
  logic at_final;
  logic final_take;

  cfb_encoder u_encoder (
    .state_i     (state_q),
    .msg_id_i    (msg_id_i),
    .frame_len_i (frame_len_i),
    .data_i      (data_i),
    .last_i      (last_i),
    .state_o     (state_d),
    .group_o     (group_d)
  );

  // output side: byte under the read pointer
  assign out_valid_o    = (cnt_q != '0);
  assign at_final       = (res_cnt_t'(ptr_q + res_cnt_t'(1)) == cnt_q);
  assign out_byte_o     = bytes_q[ptr_q];
  assign end_of_frame_o = eof_q && at_final;
  assign length_error_o = err_q && at_final;
  assign out_take       = out_valid_o && out_ready_i;
  assign final_take     = out_take && at_final;

  // a new request enters when the group is empty or is leaving this cycle
  assign in_ready_o = !out_valid_o || final_take;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRAME_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      eof_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
        cnt_q   <= group_d.count;
        ptr_q   <= '0;
        eof_q   <= group_d.closes;
        err_q   <= group_d.length_error;
      end else if (final_take) begin
        cnt_q <= '0;
        ptr_q <= '0;
      end else if (out_take) begin
        ptr_q <= ptr_q + res_cnt_t'(1);
      end
    end
  end

  // result group bytes need no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bytes_q <= group_d.bytes;
    end
  end

  // read pointer stays inside the group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ptr_q < cnt_q))
    else $error("read pointer beyond result group");

  // the closing byte is shown only after the frame state has returned to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_frame_o |-> !state_q.in_frame)
    else $error("end of frame while frame still open");

  // an error flag only rides on the closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_error_o |-> end_of_frame_o)
    else $error("length error away from end of frame");

  // a request with last always yields at least the two crc bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_i) |=> (eof_q && cnt_q >= res_cnt_t'(2)))
    else $error("closing request without crc bytes");

endmodule
